FILE: rtl/ppt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppt_pkg
// Types and constants shared by the peer probe table blocks.
// ----------------------------------------------------------------------------
package ppt_pkg;

  localparam int unsigned MacW     = 48;
  localparam int unsigned TickW    = 32;
  localparam int unsigned CountW   = 8;
  localparam int unsigned CoolW    = 16;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_FAIL_THRESHOLD = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_COOLDOWN_TICKS = 1'd1;

  localparam logic [CountW-1:0] FailThresholdReset = 8'd2;
  localparam logic [CoolW-1:0]  CooldownReset      = 16'd5000;
  localparam logic [CountW-1:0] FailMax            = 8'd255;

  // event mode codes on the input
  localparam logic [1:0] MODE_QUERY = 2'd0;
  localparam logic [1:0] MODE_FAIL  = 2'd1;
  localparam logic [1:0] MODE_ACK   = 2'd2;

  typedef enum logic [1:0] {
    OP_QUERY,
    OP_FAIL,
    OP_ACK,
    OP_IGNORE
  } op_e;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_SCAN,
    SEQ_EXEC
  } seq_e;

  typedef struct packed {
    logic [1:0]       mode;
    logic [MacW-1:0]  peer_mac;
    logic [TickW-1:0] now_tick;
  } in_item_t;

  typedef struct packed {
    logic              probing;
    logic              found;
    logic [CountW-1:0] fail_count;
    logic              entered_probing;
    logic              reclaimed;
  } out_item_t;

  // classified event as queued between front and back
  typedef struct packed {
    op_e              op;
    logic [MacW-1:0]  peer_mac;
    logic [TickW-1:0] now_tick;
  } work_t;

  // one table entry as stored in the RAM
  typedef struct packed {
    logic [MacW-1:0]   mac;
    logic [CountW-1:0] fails;
    logic [TickW-1:0]  window_end;
  } entry_t;

  typedef struct packed {
    logic [CountW-1:0] fail_threshold;
    logic [CoolW-1:0]  cooldown_ticks;
  } cfg_t;

endpackage

FILE: rtl/peer_probe_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// peer_probe_table_core
// Table of unresponsive peers keyed by 48-bit address: answers probe queries,
// records failures and frees entries on ack.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake           | Payload
//  in      | input     | in_valid_i/in_stall_o   | in_data_i  (mode, peer_mac, now_tick)
//  out     | output    | out_valid_o/out_stall_i | out_data_o (probing .. reclaimed)
//  cfg     | input     | cfg_we_i (no wait)      | cfg_idx_i, cfg_wdata_i
//
// One event at a time: the back end scans the entry RAM one entry per cycle
// (registered read) and a match ends the scan early; an unused mode skips
// the scan.
// A two-deep queue buffers events while a scan runs.
// Reset clears all entry valid bits at once; no clearing pass is needed.
// A stalled result holds the back end in its execute step; input keeps
// filling the queue until it is full.
// ----------------------------------------------------------------------------
module peer_probe_table_core #(
  parameter int unsigned ENTRIES = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  ppt_pkg::in_item_t                   in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output ppt_pkg::out_item_t                  out_data_o,
  input  logic                                cfg_we_i,
  input  logic [ppt_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [ppt_pkg::CfgDataW-1:0]        cfg_wdata_i
);

  ppt_pkg::cfg_t  cfg_q, cfg_d;
  logic           q_valid;
  ppt_pkg::work_t q_data;
  logic           q_pop;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ppt_pkg::REG_FAIL_THRESHOLD:
          cfg_d.fail_threshold = cfg_wdata_i[ppt_pkg::CountW-1:0];
        ppt_pkg::REG_COOLDOWN_TICKS:
          cfg_d.cooldown_ticks = cfg_wdata_i[ppt_pkg::CoolW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fail_threshold <= ppt_pkg::FailThresholdReset;
      cfg_q.cooldown_ticks <= ppt_pkg::CooldownReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  ppt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_valid_o  (q_valid),
    .q_data_o   (q_data),
    .q_pop_i    (q_pop)
  );

  ppt_back #(
    .ENTRIES (ENTRIES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: rtl/ppt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppt_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ppt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/ppt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppt_front
// Input side: takes events, classifies the mode and queues them (two deep).
// ----------------------------------------------------------------------------
module ppt_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  ppt_pkg::in_item_t in_data_i,
  output logic             q_valid_o,
  output ppt_pkg::work_t   q_data_o,
  input  logic             q_pop_i
);

  ppt_pkg::work_t fifo_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;
  logic           push;
  logic           pop;
  ppt_pkg::work_t item;

  always_comb begin
    item.peer_mac = in_data_i.peer_mac;
    item.now_tick = in_data_i.now_tick;
    unique case (in_data_i.mode)
      ppt_pkg::MODE_QUERY: item.op = ppt_pkg::OP_QUERY;
      ppt_pkg::MODE_FAIL:  item.op = ppt_pkg::OP_FAIL;
      ppt_pkg::MODE_ACK:   item.op = ppt_pkg::OP_ACK;
      default:             item.op = ppt_pkg::OP_IGNORE;
    endcase
  end

  assign in_stall_o = (count_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = q_pop_i && (count_q != 2'd0);
  assign q_valid_o  = (count_q != 2'd0);
  assign q_data_o   = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= item;
    end
  end

endmodule

FILE: rtl/ppt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppt_back
// Table engine: scans the entry RAM for a match and a free slot (unused modes
// skip the scan), then applies the event and loads the result register.
// ----------------------------------------------------------------------------
module ppt_back #(
  parameter int unsigned ENTRIES = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ppt_pkg::cfg_t     cfg_i,
  input  logic              q_valid_i,
  input  ppt_pkg::work_t    q_data_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ppt_pkg::out_item_t out_data_o
);

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(ENTRIES - 1);

  ppt_pkg::seq_e state_q, state_d;

  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [IdxW-1:0]    scan_idx_q, scan_idx_d;
  logic               issue_done_q, issue_done_d;
  logic               cmp_vld_q, cmp_vld_d;
  logic [IdxW-1:0]    cmp_idx_q, cmp_idx_d;
  logic               hit_q, hit_d;
  logic [IdxW-1:0]    hit_idx_q, hit_idx_d;
  logic [ppt_pkg::CountW-1:0] hit_fails_q, hit_fails_d;
  logic [ppt_pkg::TickW-1:0]  hit_end_q, hit_end_d;
  logic               free_q, free_d;
  logic [IdxW-1:0]    free_idx_q, free_idx_d;
  ppt_pkg::work_t     work_q, work_d;
  logic               out_valid_q, out_valid_d;
  ppt_pkg::out_item_t out_data_q, out_data_d;

  logic               pop;
  logic               issue;
  logic               exec_fire;
  logic               match;
  logic               scan_end;
  ppt_pkg::entry_t    rd_entry;
  ppt_pkg::entry_t    wr_entry;
  logic               ram_we;
  logic [IdxW-1:0]    slot;
  logic [ppt_pkg::CountW-1:0] old_fails;
  logic [ppt_pkg::CountW-1:0] new_fails;
  logic [ppt_pkg::TickW-1:0]  window_diff;
  logic               window_ahead;
  ppt_pkg::out_item_t result;

  ppt_ram #(
    .Width ($bits(ppt_pkg::entry_t)),
    .Depth (ENTRIES)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot),
    .wdata_i (wr_entry),
    .raddr_i (scan_idx_q),
    .rdata_o (rd_entry)
  );

  // compare stage sees the entry read in the previous cycle
  assign match    = (state_q == ppt_pkg::SEQ_SCAN) && cmp_vld_q && valid_q[cmp_idx_q]
                    && (rd_entry.mac == work_q.peer_mac);
  assign scan_end = cmp_vld_q && (cmp_idx_q == LastIdx);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ppt_pkg::SEQ_IDLE: begin
        if (q_valid_i) begin
          state_d = (q_data_i.op == ppt_pkg::OP_IGNORE) ? ppt_pkg::SEQ_EXEC
                                                        : ppt_pkg::SEQ_SCAN;
        end
      end
      ppt_pkg::SEQ_SCAN: begin
        if (match || scan_end) begin
          state_d = ppt_pkg::SEQ_EXEC;
        end
      end
      ppt_pkg::SEQ_EXEC: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = ppt_pkg::SEQ_IDLE;
        end
      end
      default: state_d = ppt_pkg::SEQ_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    pop       = 1'b0;
    issue     = 1'b0;
    exec_fire = 1'b0;
    unique case (state_q)
      ppt_pkg::SEQ_IDLE: pop       = q_valid_i;
      ppt_pkg::SEQ_SCAN: issue     = !issue_done_q;
      ppt_pkg::SEQ_EXEC: exec_fire = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  assign q_pop_o = pop;

  // event execution
  always_comb begin
    slot         = hit_q ? hit_idx_q : (free_q ? free_idx_q : '0);
    old_fails    = hit_q ? hit_fails_q : '0;
    new_fails    = (old_fails == ppt_pkg::FailMax) ? old_fails : old_fails + 8'd1;
    window_diff  = hit_end_q - work_q.now_tick;
    window_ahead = (window_diff != '0) && !window_diff[ppt_pkg::TickW-1];

    wr_entry.mac        = work_q.peer_mac;
    wr_entry.fails      = new_fails;
    wr_entry.window_end = work_q.now_tick + {16'd0, cfg_i.cooldown_ticks};

    result = '0;
    unique case (work_q.op)
      ppt_pkg::OP_QUERY: begin
        result.found      = hit_q;
        result.fail_count = hit_q ? hit_fails_q : '0;
        result.probing    = hit_q && (hit_fails_q >= cfg_i.fail_threshold) && window_ahead;
      end
      ppt_pkg::OP_FAIL: begin
        result.found           = hit_q;
        result.fail_count      = new_fails;
        result.entered_probing = (new_fails == cfg_i.fail_threshold);
        result.reclaimed       = !hit_q && !free_q;
      end
      ppt_pkg::OP_ACK: begin
        result.found = hit_q;
      end
      default: ;
    endcase

    ram_we = exec_fire && (work_q.op == ppt_pkg::OP_FAIL);
  end

  // scan bookkeeping, table valid bits and result register
  always_comb begin
    valid_d      = valid_q;
    scan_idx_d   = scan_idx_q;
    issue_done_d = issue_done_q;
    cmp_vld_d    = issue;
    cmp_idx_d    = cmp_idx_q;
    hit_d        = hit_q;
    hit_idx_d    = hit_idx_q;
    hit_fails_d  = hit_fails_q;
    hit_end_d    = hit_end_q;
    free_d       = free_q;
    free_idx_d   = free_idx_q;
    work_d       = work_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_data_d   = out_data_q;

    if (pop) begin
      work_d       = q_data_i;
      scan_idx_d   = '0;
      issue_done_d = 1'b0;
      hit_d        = 1'b0;
      free_d       = 1'b0;
    end

    if (issue) begin
      cmp_idx_d = scan_idx_q;
      if (!valid_q[scan_idx_q] && !free_q) begin
        free_d     = 1'b1;
        free_idx_d = scan_idx_q;
      end
      if (scan_idx_q == LastIdx) begin
        issue_done_d = 1'b1;
      end else begin
        scan_idx_d = scan_idx_q + IdxW'(1);
      end
    end

    if (match) begin
      hit_d       = 1'b1;
      hit_idx_d   = cmp_idx_q;
      hit_fails_d = rd_entry.fails;
      hit_end_d   = rd_entry.window_end;
    end

    if (exec_fire) begin
      out_valid_d = 1'b1;
      out_data_d  = result;
      if (work_q.op == ppt_pkg::OP_FAIL) begin
        valid_d[slot] = 1'b1;
      end else if ((work_q.op == ppt_pkg::OP_ACK) && hit_q) begin
        valid_d[hit_idx_q] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ppt_pkg::SEQ_IDLE;
      valid_q      <= '0;
      scan_idx_q   <= '0;
      issue_done_q <= 1'b0;
      cmp_vld_q    <= 1'b0;
      hit_q        <= 1'b0;
      free_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      valid_q      <= valid_d;
      scan_idx_q   <= scan_idx_d;
      issue_done_q <= issue_done_d;
      cmp_vld_q    <= cmp_vld_d;
      hit_q        <= hit_d;
      free_q       <= free_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q   <= cmp_idx_d;
    hit_idx_q   <= hit_idx_d;
    hit_fails_q <= hit_fails_d;
    hit_end_q   <= hit_end_d;
    free_idx_q  <= free_idx_d;
    work_q      <= work_d;
    out_data_q  <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for peer_probe_table_core. A scoreboard class keeps its
// own copy of the peer table, predicts one report per accepted event and
// checks every returned report field by field. Stimulus is a directed opening
// followed by random fill, hammer, ack and noise sequences, under several
// threshold and cooldown settings, with bursty input and patterned output
// stalls.
// ----------------------------------------------------------------------------
module testbench;
  import ppt_pkg::*;

  localparam int unsigned NumEntries  = 32;
  localparam int unsigned PoolSize    = 40;   // more peers than entries, so the table fills
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 40;
  localparam logic [1:0]  ModeUnused  = 2'(OP_IGNORE);

  class probe_scoreboard;
    logic [CountW-1:0] threshold;
    logic [CoolW-1:0]  cooldown;
    bit                entry_live [NumEntries];
    logic [MacW-1:0]   entry_mac [NumEntries];
    logic [CountW-1:0] entry_fails [NumEntries];
    logic [TickW-1:0]  window_end [NumEntries];
    out_item_t         pending_reports [$];
    int unsigned       errors;

    function new();
      threshold = FailThresholdReset;
      cooldown  = CooldownReset;
      errors    = 0;
      foreach (entry_live[i]) entry_live[i] = 1'b0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
      case (idx)
        REG_FAIL_THRESHOLD: threshold = value[CountW-1:0];
        REG_COOLDOWN_TICKS: cooldown  = value[CoolW-1:0];
        default: ;
      endcase
    endfunction

    // lowest valid entry holding the address, -1 if none
    function int find(logic [MacW-1:0] mac);
      for (int i = 0; i < NumEntries; i++)
        if (entry_live[i] && entry_mac[i] == mac) return i;
      return -1;
    endfunction

    function int pending();
      return pending_reports.size();
    endfunction

    function void note_event(in_item_t ev);
      out_item_t        rep;
      int               hit;
      int               slot;
      logic [TickW-1:0] delta;
      rep = '0;
      hit = find(ev.peer_mac);
      case (ev.mode)
        MODE_QUERY: begin
          if (hit >= 0) begin
            rep.found      = 1'b1;
            rep.fail_count = entry_fails[hit];
            delta = window_end[hit] - ev.now_tick;
            rep.probing = (entry_fails[hit] >= threshold) && delta != '0 && !delta[TickW-1];
          end
        end
        MODE_FAIL: begin
          slot = hit;
          if (slot >= 0) begin
            rep.found = 1'b1;
          end else begin
            for (int i = 0; i < NumEntries; i++)
              if (!entry_live[i] && slot < 0) slot = i;
            if (slot < 0) begin
              slot = 0;
              rep.reclaimed = 1'b1;
            end
            entry_mac[slot]   = ev.peer_mac;
            entry_fails[slot] = '0;
            entry_live[slot]  = 1'b1;
          end
          if (entry_fails[slot] != FailMax) entry_fails[slot] = entry_fails[slot] + 1'b1;
          window_end[slot]    = ev.now_tick + TickW'(cooldown);
          rep.fail_count      = entry_fails[slot];
          rep.entered_probing = (entry_fails[slot] == threshold);
        end
        MODE_ACK: begin
          if (hit >= 0) begin
            rep.found       = 1'b1;
            entry_live[hit] = 1'b0;
          end
        end
        default: ;  // unused mode: all fields zero
      endcase
      pending_reports.push_back(rep);
    endfunction

    function void compare_field(string name, logic [CountW-1:0] want, logic [CountW-1:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_report(out_item_t got);
      out_item_t want;
      if (pending_reports.size() == 0) begin
        errors++;
        $display("%0t: unexpected report, expected none actual %p", $time, got);
        return;
      end
      want = pending_reports.pop_front();
      compare_field("probing", CountW'(want.probing), CountW'(got.probing));
      compare_field("found", CountW'(want.found), CountW'(got.found));
      compare_field("fail_count", want.fail_count, got.fail_count);
      compare_field("entered_probing", CountW'(want.entered_probing),
                    CountW'(got.entered_probing));
      compare_field("reclaimed", CountW'(want.reclaimed), CountW'(got.reclaimed));
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  in_item_t            in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  out_item_t           out_data_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  probe_scoreboard     scoreboard;
  logic [MacW-1:0]     mac_pool [PoolSize];
  logic [TickW-1:0]    tick_base;
  int unsigned         gap_max;
  int unsigned         burst_left;
  int unsigned         events_sent;
  logic                hold_req;

  peer_probe_table_core #(
    .ENTRIES(NumEntries)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result side: randomly chosen stall patterns, long hold on request
  initial begin
    logic [15:0] pat;
    int unsigned age;
    out_stall_i = 1'b0;
    pat = '0;
    age = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req    = 1'b0;
        out_stall_i = 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
      end
      if (age == 0) begin
        age = $urandom_range(16, 96);
        case ($urandom_range(0, 3))
          0: pat = '0;
          1: pat = 16'($urandom);
          2: pat = 16'($urandom & $urandom);
          default: pat = 16'($urandom | $urandom);
        endcase
      end
      age--;
      out_stall_i = pat[0];
      pat = {pat[0], pat[15:1]};
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) scoreboard.check_report(out_data_o);
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_event(input logic [1:0] mode, input logic [MacW-1:0] mac,
                            input logic [TickW-1:0] now);
    in_item_t ev;
    ev.mode     = mode;
    ev.peer_mac = mac;
    ev.now_tick = now;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      repeat ($urandom_range(0, gap_max)) begin
        in_valid_i = 1'b0;
        @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i = 1'b1;
    in_data_i  = ev;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    scoreboard.note_event(ev);
    events_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    scoreboard.set_reg(idx, value);
  endtask

  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (scoreboard.pending() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // ticks near the peer's window edges, near the running clock, or anywhere
  function automatic logic [TickW-1:0] pick_now(input logic [MacW-1:0] mac);
    int          slot;
    int unsigned r;
    slot = scoreboard.find(mac);
    r = $urandom_range(0, 9);
    if (slot >= 0 && r < 4)
      return scoreboard.window_end[slot] - 32'd2 + TickW'($urandom_range(0, 4));
    if (slot >= 0 && r == 4)
      return scoreboard.window_end[slot] + 32'h7FFF_FFFF + TickW'($urandom_range(0, 2));
    if (r == 5) return TickW'($urandom);
    tick_base += TickW'($urandom_range(0, scoreboard.cooldown / 4 + 1));
    return tick_base;
  endfunction

  task automatic random_phase(input int unsigned count);
    int unsigned     target;
    int unsigned     k;
    int unsigned     start;
    int unsigned     r;
    logic [MacW-1:0] mac;
    target = events_sent + count;
    while (events_sent < target) begin
      r = $urandom_range(0, 9);
      if (r < 2) begin
        // run of failures on distinct peers, often enough to fill the table
        k = $urandom_range(20, PoolSize);
        start = $urandom_range(0, PoolSize - 1);
        for (int j = 0; j < k; j++) begin
          mac = mac_pool[(start + j) % PoolSize];
          send_event(MODE_FAIL, mac, pick_now(mac));
        end
      end else if (r < 6) begin
        mac = mac_pool[$urandom_range(0, PoolSize - 1)];
        repeat ($urandom_range(2, 14)) begin
          k = $urandom_range(0, 9);
          if (k < 5) send_event(MODE_FAIL, mac, pick_now(mac));
          else if (k < 9) send_event(MODE_QUERY, mac, pick_now(mac));
          else send_event(MODE_ACK, mac, pick_now(mac));
        end
      end else if (r < 8) begin
        repeat ($urandom_range(1, 10)) begin
          mac = mac_pool[$urandom_range(0, PoolSize - 1)];
          send_event(MODE_ACK, mac, pick_now(mac));
        end
      end else begin
        repeat ($urandom_range(1, 6))
          send_event(2'($urandom_range(0, 3)), {16'($urandom), 32'($urandom)},
                     TickW'($urandom));
      end
    end
  endtask

  initial begin
    logic [MacW-1:0] peer_a;
    logic [MacW-1:0] peer_b;
    logic [MacW-1:0] peer_c;
    scoreboard  = new();
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = REG_FAIL_THRESHOLD;
    cfg_wdata_i = '0;
    hold_req    = 1'b0;
    gap_max     = 4;
    burst_left  = 0;
    events_sent = 0;
    tick_base   = 32'hFFFF_0000;  // wraps early in the run
    peer_a = '1;
    peer_b = '0;
    peer_c = 48'h8000_0000_0001;
    mac_pool[0] = peer_a;
    mac_pool[1] = peer_b;
    for (int i = 2; i < PoolSize; i++) mac_pool[i] = {16'($urandom), 32'($urandom)};

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: misses, unused mode, threshold crossing, window edges across wrap
    send_event(MODE_QUERY, peer_a, 32'd0);
    send_event(MODE_ACK, peer_a, 32'd0);
    send_event(ModeUnused, peer_a, 32'hFFFF_FFFF);
    send_event(MODE_FAIL, peer_a, 32'hFFFF_FFF0);
    send_event(MODE_QUERY, peer_a, 32'hFFFF_FFF0);
    send_event(MODE_FAIL, peer_a, 32'hFFFF_FFFF);    // window end wraps to 4999
    send_event(MODE_QUERY, peer_a, 32'd0);
    send_event(MODE_QUERY, peer_a, 32'd4999);
    send_event(MODE_QUERY, peer_a, 32'd4998);
    send_event(MODE_QUERY, peer_a, 32'd4999 - 32'h7FFF_FFFF);
    send_event(MODE_QUERY, peer_a, 32'd4999 - 32'h8000_0000);
    send_event(MODE_FAIL, peer_b, 32'd0);
    send_event(MODE_FAIL, peer_a, 32'd100);
    send_event(MODE_ACK, peer_a, 32'd200);
    send_event(MODE_QUERY, peer_a, 32'd300);
    send_event(MODE_FAIL, peer_c, 32'd400);          // takes the freed lowest entry
    send_event(MODE_ACK, peer_b, 32'd500);
    send_event(ModeUnused, peer_c, 32'd600);
    send_event(MODE_QUERY, peer_c, 32'd700);

    random_phase(300);
    wait_idle();

    // saturation of one peer's count with the highest threshold
    gap_max = 0;
    write_reg(REG_FAIL_THRESHOLD, CfgDataW'(FailMax));
    write_reg(REG_COOLDOWN_TICKS, 16'hFFFF);
    for (int i = 0; i < 270; i++) begin
      send_event(MODE_FAIL, mac_pool[2], pick_now(mac_pool[2]));
      if ($urandom_range(0, 5) == 0) send_event(MODE_QUERY, mac_pool[2], pick_now(mac_pool[2]));
    end
    wait_idle();

    gap_max = 6;
    write_reg(REG_FAIL_THRESHOLD, 16'd1);
    write_reg(REG_COOLDOWN_TICKS, 16'd1);
    random_phase(200);
    wait_idle();

    // threshold zero: queries depend on the window alone; long output hold here
    gap_max = 2;
    write_reg(REG_FAIL_THRESHOLD, 16'd0);
    write_reg(REG_COOLDOWN_TICKS, 16'($urandom_range(1, 3000)));
    hold_req = 1'b1;
    random_phase(200);
    wait_idle();

    gap_max = 8;
    write_reg(REG_FAIL_THRESHOLD, 16'($urandom_range(1, 6)));
    write_reg(REG_COOLDOWN_TICKS, 16'($urandom_range(1, 65535)));
    random_phase(300);
    wait_idle();

    if (scoreboard.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
